### hw/rtl/rcpn_pkg.sv
// Shared constants, codes and types of the RC pulse capture normalizer.
package rcpn_pkg;

  // Channel count and index width
  localparam int CHANNELS = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int CH_W   = 3;
  localparam int TIME_W = 32;
  localparam int PW_W   = 16;
  localparam int VAL_W  = 16;
  localparam int KIND_W = 2;
  localparam int DZ_W   = 10;
  localparam int CFG_W  = 32;
  localparam int CIDX_W = 2;

  // Command codes
  localparam logic [1:0] CMD_EDGE  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_LOAD  = 2'd2;

  // Channel kinds
  localparam logic [KIND_W-1:0] KIND_TWO   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_THREE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STICK = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] REG_DEADZONE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_WINDOW   = 2'd1;
  localparam logic [CIDX_W-1:0] REG_TIMEOUT  = 2'd2;

  // Register reset values
  localparam logic [DZ_W-1:0]   DEADZONE_RST = 10'd10;
  localparam logic [DZ_W-1:0]   WINDOW_RST   = 10'd100;
  localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd500000;

  // Q2.14 unit and divider length (quotient stays below one)
  localparam int Q_BITS    = 14;
  localparam int DIV_CNT_W = $clog2(Q_BITS);

  // Per-channel settings
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PW_W-1:0]   min_us;
    logic [PW_W-1:0]   mid_us;
    logic [PW_W-1:0]   max_us;
  } chan_cfg_t;

endpackage

### hw/rtl/rcpn_div.sv
// Iterative restoring divider: (num << 14) / den, one quotient bit per cycle.
module rcpn_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [rcpn_pkg::PW_W-1:0]           num,
  input  logic [rcpn_pkg::PW_W-1:0]           den,
  output logic                                done,
  output logic [rcpn_pkg::Q_BITS-1:0]         quot
);

  logic [rcpn_pkg::PW_W:0]          rem_r;
  logic [rcpn_pkg::PW_W-1:0]        den_r;
  logic [rcpn_pkg::Q_BITS-1:0]      quot_r;
  logic [rcpn_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic                             busy_r;
  logic                             done_r;

  logic [rcpn_pkg::PW_W:0]          rem_sh;
  logic                             q_bit;
  logic [rcpn_pkg::PW_W:0]          rem_nxt;

  // One shift-compare-subtract step; remainder stays below den
  always_comb begin
    rem_sh  = {rem_r[rcpn_pkg::PW_W-1:0], 1'b0};
    q_bit   = (rem_sh >= {1'b0, den_r});
    rem_nxt = q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rcpn_pkg::DIV_CNT_W'(rcpn_pkg::Q_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= {1'b0, num};
      den_r  <= den;
      quot_r <= '0;
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      quot_r <= {quot_r[rcpn_pkg::Q_BITS-2:0], q_bit};
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### hw/rtl/rc_pulse_capture_normalizer.sv
// Top level: channel store, item sequencer and result register.
//
// Multi-channel RC pulse receiver. Input beats carry a command (pin edge,
// query, or load of channel settings), a channel and a microsecond stamp;
// every accepted beat yields exactly one result beat with the channel's
// pulse width, its normalized Q2.14 value and a failsafe flag.
// Configuration (deadzone, switch window, failsafe timeout) is written on
// cfg_we with cfg_index / cfg_wdata; the user must write it only while the
// block is idle, as the block itself does not enforce this. An item passes
// from acceptance through the update, classify and done states to the
// output register; a stick value between deadzone and limits also passes
// through the divide state, where the shared divider resolves one quotient
// bit per cycle. One item is in flight at a time: in_stall is high from
// acceptance until the result moves into the output register. The output
// register holds its beat while out_stall is high; a new item may be
// accepted meanwhile, but its result waits until the held beat is taken.
// Synchronous reset clears all channel state, settings (two-position kind,
// zero limits), the last-edge time and the configuration registers to their defaults.
module rc_pulse_capture_normalizer (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic [rcpn_pkg::CIDX_W-1:0]        cfg_index,
  input  logic [rcpn_pkg::CFG_W-1:0]         cfg_wdata,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [1:0]                         in_command,
  input  logic [rcpn_pkg::CH_W-1:0]          in_channel,
  input  logic                               in_level,
  input  logic [rcpn_pkg::TIME_W-1:0]        in_time_us,
  input  logic [rcpn_pkg::KIND_W-1:0]        in_cfg_kind,
  input  logic [rcpn_pkg::PW_W-1:0]          in_cfg_min_us,
  input  logic [rcpn_pkg::PW_W-1:0]          in_cfg_mid_us,
  input  logic [rcpn_pkg::PW_W-1:0]          in_cfg_max_us,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [rcpn_pkg::CH_W-1:0]          out_channel,
  output logic [rcpn_pkg::PW_W-1:0]          out_pulse_width,
  output logic signed [rcpn_pkg::VAL_W-1:0]  out_value,
  output logic                               out_failsafe
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_UPD   = 5'b00010,
    S_CLASS = 5'b00100,
    S_DIV   = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic signed [rcpn_pkg::VAL_W-1:0] VAL_POS =
    rcpn_pkg::VAL_W'(1 << rcpn_pkg::Q_BITS);
  localparam logic signed [rcpn_pkg::VAL_W-1:0] VAL_NEG = -VAL_POS;

  // Registers
  state_t                              state_r, state_nxt;
  logic [rcpn_pkg::DZ_W-1:0]           deadzone_r;
  logic [rcpn_pkg::DZ_W-1:0]           window_r;
  logic [rcpn_pkg::TIME_W-1:0]         timeout_r;

  logic [rcpn_pkg::TIME_W-1:0]         rise_time_r [rcpn_pkg::CHANNELS];
  logic [rcpn_pkg::PW_W-1:0]           width_r     [rcpn_pkg::CHANNELS];
  rcpn_pkg::chan_cfg_t                 chan_tab_r  [rcpn_pkg::CHANNELS];
  logic [rcpn_pkg::TIME_W-1:0]         last_edge_r;

  logic [1:0]                          cmd_r;
  logic [rcpn_pkg::CH_W-1:0]           ch_r;
  logic                                lvl_r;
  logic [rcpn_pkg::TIME_W-1:0]         now_r;
  rcpn_pkg::chan_cfg_t                 new_cfg_r;

  logic                                fs_r;
  logic                                neg_r;
  logic signed [rcpn_pkg::VAL_W-1:0]   val_r;

  logic                                out_valid_r;
  logic [rcpn_pkg::CH_W-1:0]           out_ch_r;
  logic [rcpn_pkg::PW_W-1:0]           out_pw_r;
  logic signed [rcpn_pkg::VAL_W-1:0]   out_val_r;
  logic                                out_fs_r;

  // Combinational
  logic                                in_acc;
  logic                                ch_ok;
  logic [rcpn_pkg::CH_IDX_W-1:0]       idx;
  logic [rcpn_pkg::TIME_W-1:0]         last_edge_nxt;
  logic [rcpn_pkg::PW_W-1:0]           cur_w;
  rcpn_pkg::chan_cfg_t                 cur_cfg;
  logic                                out_load;

  logic [rcpn_pkg::PW_W:0]             d_min, d_mid, d_max;
  logic signed [rcpn_pkg::PW_W:0]      err;
  logic [rcpn_pkg::PW_W:0]             err_mag;
  logic [rcpn_pkg::PW_W-1:0]           span;
  logic                                need_div;
  logic signed [rcpn_pkg::VAL_W-1:0]   class_val;

  logic                                div_start;
  logic                                div_done;
  logic [rcpn_pkg::Q_BITS-1:0]         div_quot;
  logic signed [rcpn_pkg::VAL_W-1:0]   div_val;

  function automatic logic [rcpn_pkg::PW_W:0] abs_diff(
    input logic [rcpn_pkg::PW_W-1:0] a,
    input logic [rcpn_pkg::PW_W-1:0] b
  );
    logic [rcpn_pkg::PW_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return d[rcpn_pkg::PW_W] ? -d : d;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign ch_ok    = (32'(ch_r) < rcpn_pkg::CHANNELS);
  assign idx      = ch_r[rcpn_pkg::CH_IDX_W-1:0];
  assign cur_w    = width_r[idx];
  assign cur_cfg  = chan_tab_r[idx];
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // Last-edge time as seen by this item's failsafe check
  always_comb begin
    last_edge_nxt = last_edge_r;
    if (ch_ok && cmd_r == rcpn_pkg::CMD_EDGE) begin
      last_edge_nxt = now_r;
    end
  end

  // Value classification from the updated channel entry
  always_comb begin
    d_min     = abs_diff(cur_w, cur_cfg.min_us);
    d_mid     = abs_diff(cur_w, cur_cfg.mid_us);
    d_max     = abs_diff(cur_w, cur_cfg.max_us);
    err       = $signed({1'b0, cur_w}) - $signed({1'b0, cur_cfg.mid_us});
    err_mag   = err[rcpn_pkg::PW_W] ? 17'(-err) : 17'(err);
    span      = err[rcpn_pkg::PW_W] ? (cur_cfg.mid_us - cur_cfg.min_us)
                                    : (cur_cfg.max_us - cur_cfg.mid_us);
    need_div  = 1'b0;
    class_val = '0;
    if (ch_ok) begin
      unique case (cur_cfg.kind)
        rcpn_pkg::KIND_TWO: begin
          class_val = VAL_POS;
        end
        rcpn_pkg::KIND_THREE: begin
          priority if (d_min <= {7'b0, window_r}) class_val = VAL_POS;
          else if (d_mid <= {7'b0, window_r})     class_val = '0;
          else if (d_max <= {7'b0, window_r})     class_val = VAL_NEG;
          else                                    class_val = '0;
        end
        rcpn_pkg::KIND_STICK: begin
          priority if (cur_w <= cur_cfg.min_us)    class_val = VAL_NEG;
          else if (cur_w >= cur_cfg.max_us)        class_val = VAL_POS;
          else if (err_mag < {7'b0, deadzone_r})   class_val = '0;
          else if (span == '0)                     class_val = '0;
          else                                     need_div  = 1'b1;
        end
        default: begin
          class_val = '0;
        end
      endcase
    end
  end

  assign div_start = (state_r == S_CLASS) && need_div;
  assign div_val   = neg_r ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});

  rcpn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (err_mag[rcpn_pkg::PW_W-1:0]),
    .den   (span),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_UPD;
      S_UPD:   state_nxt = S_CLASS;
      S_CLASS: state_nxt = need_div ? S_DIV : S_DONE;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= rcpn_pkg::DEADZONE_RST;
      window_r   <= rcpn_pkg::WINDOW_RST;
      timeout_r  <= rcpn_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      if (cfg_index == rcpn_pkg::REG_DEADZONE) deadzone_r <= cfg_wdata[rcpn_pkg::DZ_W-1:0];
      if (cfg_index == rcpn_pkg::REG_WINDOW)   window_r   <= cfg_wdata[rcpn_pkg::DZ_W-1:0];
      if (cfg_index == rcpn_pkg::REG_TIMEOUT)  timeout_r  <= cfg_wdata;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r            <= in_command;
      ch_r             <= in_channel;
      lvl_r            <= in_level;
      now_r            <= in_time_us;
      new_cfg_r.kind   <= in_cfg_kind;
      new_cfg_r.min_us <= in_cfg_min_us;
      new_cfg_r.mid_us <= in_cfg_mid_us;
      new_cfg_r.max_us <= in_cfg_max_us;
    end
  end

  // Channel state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < rcpn_pkg::CHANNELS; i++) begin
        rise_time_r[i] <= '0;
        width_r[i]     <= '0;
        chan_tab_r[i]  <= '0;
      end
      last_edge_r <= '0;
    end else if (state_r == S_UPD) begin
      last_edge_r <= last_edge_nxt;
      if (ch_ok && cmd_r == rcpn_pkg::CMD_EDGE) begin
        if (lvl_r) begin
          rise_time_r[idx] <= now_r;
        end else begin
          width_r[idx] <= rcpn_pkg::PW_W'(now_r - rise_time_r[idx]);
        end
      end
      if (ch_ok && cmd_r == rcpn_pkg::CMD_LOAD) begin
        chan_tab_r[idx] <= new_cfg_r;
      end
    end
  end

  // Failsafe and value
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      fs_r <= ((now_r - last_edge_nxt) > timeout_r);
    end
    if (state_r == S_CLASS) begin
      val_r <= class_val;
      neg_r <= err[rcpn_pkg::PW_W];
    end
    if (state_r == S_DIV && div_done) begin
      val_r <= div_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch_r  <= ch_r;
      out_pw_r  <= ch_ok ? cur_w : '0;
      out_val_r <= val_r;
      out_fs_r  <= fs_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_channel     = out_ch_r;
  assign out_pulse_width = out_pw_r;
  assign out_value       = out_val_r;
  assign out_failsafe    = out_fs_r;

endmodule
